### rtl/core/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

	localparam int BYTE_BITS       = 8;
	localparam int DELTA_BITS      = 9;
	localparam int SIZE_BITS       = 13;
	localparam int COORD_BITS_DEF  = 12;

	localparam logic [SIZE_BITS-1:0] COLS_RESET = 13'd640;
	localparam logic [SIZE_BITS-1:0] ROWS_RESET = 13'd480;

	localparam int STATUS_XSIGN = 4;
	localparam int STATUS_YSIGN = 5;

	typedef enum logic [0:0] {
		CFG_SCREEN_COLUMNS = 1'b0,
		CFG_SCREEN_ROWS    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_STATUS = 2'd0,
		PH_X      = 2'd1,
		PH_Y      = 2'd2
	} phase_t;

	typedef struct packed {
		logic                         consume;
		logic                         fire;
		logic signed [DELTA_BITS-1:0] dx;
		logic signed [DELTA_BITS-1:0] dy;
	} pkt_t;

endpackage

### rtl/core/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// A byte is registered in byte_s1 when it is accepted; when the third byte of
// a packet is held there and the output is free, the packet fires and the
// new position is registered in the output word.
// Throughput: one byte per cycle while out_stall does not hold back a third byte.
// Reset: asynchronous; clears byte phase and position, loads 640 x 480.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker import ps2mct_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_BITS-1:0]  rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] cursor_col,
	output logic [COORD_BITS-1:0] cursor_row,
	input  logic                  cfg_wr_en,
	input  logic [0:0]            cfg_index,
	input  logic [SIZE_BITS-1:0]  cfg_data
);

	logic [SIZE_BITS-1:0]  cols_q;
	logic [SIZE_BITS-1:0]  rows_q;
	logic                  valid_s1;
	logic [BYTE_BITS-1:0]  byte_s1;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic                  out_free;
	logic [COORD_BITS-1:0] next_col;
	logic [COORD_BITS-1:0] next_row;
	pkt_t                  pkt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_COLUMNS: cols_q <= cfg_data;
				CFG_SCREEN_ROWS:    rows_q <= cfg_data;
				default:            cols_q <= cols_q;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !pkt.consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (pkt.consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	ps2mct_packet u_packet (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(valid_s1),
		.byte_data (byte_s1),
		.out_free  (out_free),
		.pkt       (pkt)
	);

	ps2mct_cursor #(
		.COORD_BITS(COORD_BITS)
	) u_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (pkt.fire),
		.dx      (pkt.dx),
		.dy      (pkt.dy),
		.cols    (cols_q),
		.rows    (rows_q),
		.next_col(next_col),
		.next_row(next_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pkt.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.fire) begin
			col_q <= next_col;
			row_q <= next_row;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_col = col_q;
	assign cursor_row = row_q;

endmodule

### rtl/core/ps2mct_packet.sv
// ----------------------------------------------------------------------------
// ps2mct_packet
// Groups mouse bytes into three-byte packets and forms the signed deltas.
// ----------------------------------------------------------------------------
module ps2mct_packet import ps2mct_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic [BYTE_BITS-1:0] byte_data,
	input  logic                 out_free,
	output pkt_t                 pkt
);

	phase_t               phase_q;
	phase_t               phase_d;
	logic [BYTE_BITS-1:0] status_q;
	logic [BYTE_BITS-1:0] xbyte_q;
	logic                 last_byte;

	always_comb begin
		last_byte   = (phase_q == PH_Y);
		pkt.fire    = byte_valid && last_byte && out_free;
		pkt.consume = byte_valid && (!last_byte || out_free);
		pkt.dx      = {status_q[STATUS_XSIGN], xbyte_q};
		pkt.dy      = {status_q[STATUS_YSIGN], byte_data};
		phase_d     = phase_q;
		if (pkt.consume) begin
			unique case (phase_q)
				PH_X:    phase_d = PH_Y;
				PH_Y:    phase_d = PH_STATUS;
				default: phase_d = PH_X;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STATUS;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			xbyte_q  <= '0;
		end else if (pkt.consume) begin
			unique case (phase_q)
				PH_X: begin
					xbyte_q <= byte_data;
				end
				PH_Y: begin
					xbyte_q <= xbyte_q;
				end
				default: begin
					status_q <= byte_data;
				end
			endcase
		end
	end

endmodule

### rtl/core/ps2mct_cursor.sv
// ----------------------------------------------------------------------------
// ps2mct_cursor
// Holds the cursor position and applies one packet's deltas with clamping.
// ----------------------------------------------------------------------------
module ps2mct_cursor import ps2mct_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic signed [DELTA_BITS-1:0] dx,
	input  logic signed [DELTA_BITS-1:0] dy,
	input  logic [SIZE_BITS-1:0]         cols,
	input  logic [SIZE_BITS-1:0]         rows,
	output logic [COORD_BITS-1:0]        next_col,
	output logic [COORD_BITS-1:0]        next_row
);

	localparam int LW = (SIZE_BITS > COORD_BITS ? SIZE_BITS : COORD_BITS) + 1;
	localparam int SW = COORD_BITS + 2;
	localparam logic [LW-1:0] CMAX = LW'((64'd1 << COORD_BITS) - 64'd1);

	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [LW-1:0]         col_lim_w;
	logic [LW-1:0]         row_lim_w;
	logic [COORD_BITS-1:0] col_lim;
	logic [COORD_BITS-1:0] row_lim;
	logic signed [SW-1:0]  col_sum;
	logic signed [SW-1:0]  row_sum;

	always_comb begin
		col_lim_w = (cols == '0) ? '0 : LW'(cols - 1'b1);
		row_lim_w = (rows == '0) ? '0 : LW'(rows - 1'b1);
		col_lim   = (col_lim_w > CMAX) ? CMAX[COORD_BITS-1:0] : col_lim_w[COORD_BITS-1:0];
		row_lim   = (row_lim_w > CMAX) ? CMAX[COORD_BITS-1:0] : row_lim_w[COORD_BITS-1:0];

		col_sum = $signed({2'b00, col_q}) + $signed({{(SW-DELTA_BITS){dx[DELTA_BITS-1]}}, dx});
		row_sum = $signed({2'b00, row_q}) - $signed({{(SW-DELTA_BITS){dy[DELTA_BITS-1]}}, dy});

		if (col_sum < 0)
			next_col = '0;
		else if (col_sum > $signed({2'b00, col_lim}))
			next_col = col_lim;
		else
			next_col = col_sum[COORD_BITS-1:0];

		if (row_sum < 0)
			next_row = '0;
		else if (row_sum > $signed({2'b00, row_lim}))
			next_row = row_lim;
		else
			next_row = row_sum[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			col_q <= next_col;
			row_q <= next_row;
		end
	end

endmodule
